// ----- hw/rtl/mspt_pkg.sv -----
// Package for the multi-axis step pulse timer.
// Holds the item types, the lane control and status types and the register codes.
// No dependencies.
package mspt_pkg;

    localparam int IN_AXES      = 4;   // axes carried by an item (X, Y, Z, E)
    localparam int ENDSTOP_AXES = 3;   // axes with a min endstop (X, Y, Z)
    localparam int IN_STEP_BITS = 24;
    localparam int PERIOD_BITS  = 32;
    localparam int CFG_DATA_BITS = 4;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CFG_ENDSTOP_LEVEL   = 2'd0,
        CFG_ENDSTOP_PRESENT = 2'd1,
        CFG_DIR_INVERT      = 2'd2,
        CFG_DISABLE_AFTER   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_kind                           kind;
        logic [IN_STEP_BITS-1:0]         steps_x;
        logic [IN_STEP_BITS-1:0]         steps_y;
        logic [IN_STEP_BITS-1:0]         steps_z;
        logic [IN_STEP_BITS-1:0]         steps_e;
        logic [PERIOD_BITS-1:0]          period_x;
        logic [PERIOD_BITS-1:0]          period_y;
        logic [PERIOD_BITS-1:0]          period_z;
        logic [PERIOD_BITS-1:0]          period_e;
        logic [IN_AXES-1:0]              positive_mask;
        logic [ENDSTOP_AXES-1:0]         endstop_pins;
    } t_in_item;

    typedef struct packed {
        logic [IN_AXES-1:0]      step_pulses;
        logic [IN_AXES-1:0]      dir_pins;
        logic [IN_AXES-1:0]      enable_pins;
        logic [IN_AXES-1:0]      active_axes;
        logic [ENDSTOP_AXES-1:0] endstop_hits;
        logic                    busy_res;
    } t_out_item;

    // Per-axis control from the top level; load and tick are already qualified
    // by the compute stage firing.
    typedef struct packed {
        logic load;
        logic tick;
        logic kill;   // endstop hit: clear steps and elapsed count
    } t_lane_ctrl;

    typedef struct packed {
        logic was_live;   // steps remaining before this transaction
        logic live_pre;   // steps remaining after load/step, before endstop
        logic pulse;
    } t_lane_stat;

endpackage

// ----- hw/rtl/mspt_axis.sv -----
// One axis lane of the step pulse timer: step count, period and elapsed counter.
// Depends on mspt_pkg.
module mspt_axis #(
    parameter int STEP_COUNT_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mspt_pkg::t_lane_ctrl                 i_ctrl,
    input  logic [mspt_pkg::IN_STEP_BITS-1:0]    i_steps,
    input  logic [mspt_pkg::PERIOD_BITS-1:0]     i_period,
    output mspt_pkg::t_lane_stat                 o_stat
);
    import mspt_pkg::*;

    logic [STEP_COUNT_BITS-1:0] r_steps, n_steps, steps_ld, steps_pre;
    logic [PERIOD_BITS-1:0]     r_period, n_period;
    logic [PERIOD_BITS-1:0]     r_elapsed, n_elapsed, elapsed_inc, elapsed_pre;
    logic                       step_due;
    logic                       pulse;

    assign steps_ld    = STEP_COUNT_BITS'(i_steps);
    // saturating increment
    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
    assign step_due    = (elapsed_inc >= r_period);

    always_comb begin
        steps_pre   = r_steps;
        elapsed_pre = r_elapsed;
        n_period    = r_period;
        pulse       = 1'b0;
        if (i_ctrl.load) begin
            steps_pre   = steps_ld;
            elapsed_pre = '0;
            n_period    = i_period;
        end else if (i_ctrl.tick && (r_steps != '0)) begin
            if (step_due) begin
                pulse       = 1'b1;
                steps_pre   = r_steps - 1'b1;
                elapsed_pre = '0;
            end else begin
                elapsed_pre = elapsed_inc;
            end
        end
        n_steps   = i_ctrl.kill ? '0 : steps_pre;
        n_elapsed = i_ctrl.kill ? '0 : elapsed_pre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps   <= '0;
            r_period  <= '0;
            r_elapsed <= '0;
        end else begin
            r_steps   <= n_steps;
            r_period  <= n_period;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_stat.was_live = (r_steps != '0);
    assign o_stat.live_pre = (steps_pre != '0);
    assign o_stat.pulse    = pulse;

endmodule

// ----- hw/rtl/multi_axis_step_pulse_timer.sv -----
// Multi-axis step pulse timer, top level: input register, axis lanes, endstop
// and driver enable logic, configuration registers, result register.
// Depends on mspt_pkg and mspt_axis.
//
// Usage: a load transaction (kind = load) latches the step counts, step periods
// and directions of a new move, enables every driver with steps and clears the
// elapsed counters; each tick transaction (kind = tick) advances all busy axes by
// one tick, and an axis whose elapsed count reaches its period reports a step
// pulse and counts one step down. Min endstops on X, Y and Z stop a negative
// move; when the move ends, drivers flagged in the disable mask switch off.
// Every transaction yields exactly one result. The block takes one transaction
// per clock unless an unread result stalls it; the input register captures it
// and the single-pass lane update then loads the result register. Ticks are
// meant to be issued once per clock, so step timing resolution is one tick.
// The user is to write configuration registers through the cfg channel only
// while idle; the block does not enforce this. o_cfg_ready is always high.
// No clearing pass is needed after reset.
module multi_axis_step_pulse_timer #(
    parameter int AXES            = 4,
    parameter int STEP_COUNT_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  mspt_pkg::t_in_item                      i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output mspt_pkg::t_out_item                     o_out_data,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  mspt_pkg::t_cfg_index                    i_cfg_index,
    input  logic [mspt_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import mspt_pkg::*;

    // ---- configuration registers ----
    logic                    r_cfg_level;
    logic [ENDSTOP_AXES-1:0] r_cfg_present;
    logic [IN_AXES-1:0]      r_cfg_dir_inv;
    logic [IN_AXES-1:0]      r_cfg_disable;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_level   <= 1'b0;
            r_cfg_present <= '1;
            r_cfg_dir_inv <= '0;
            r_cfg_disable <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENDSTOP_LEVEL:   r_cfg_level   <= i_cfg_data[0];
                CFG_ENDSTOP_PRESENT: r_cfg_present <= i_cfg_data[ENDSTOP_AXES-1:0];
                CFG_DIR_INVERT:      r_cfg_dir_inv <= i_cfg_data[IN_AXES-1:0];
                CFG_DISABLE_AFTER:   r_cfg_disable <= i_cfg_data[IN_AXES-1:0];
                default: ;
            endcase
        end
    end

    // ---- input register and handshake ----
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item res;
    logic      fire;      // compute stage consumes the held transaction
    logic      is_load;
    logic      is_tick;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign is_load    = fire && (r_in.kind == KIND_LOAD);
    assign is_tick    = fire && (r_in.kind == KIND_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // ---- axis lanes ----
    logic [IN_STEP_BITS-1:0] in_steps  [IN_AXES];
    logic [PERIOD_BITS-1:0]  in_period [IN_AXES];

    assign in_steps[0]  = r_in.steps_x;
    assign in_steps[1]  = r_in.steps_y;
    assign in_steps[2]  = r_in.steps_z;
    assign in_steps[3]  = r_in.steps_e;
    assign in_period[0] = r_in.period_x;
    assign in_period[1] = r_in.period_y;
    assign in_period[2] = r_in.period_z;
    assign in_period[3] = r_in.period_e;

    logic [AXES-1:0] was_live, live_pre, live_after, pulse, hit;
    logic [AXES-1:0] load_pos, dis_ax, mp_next;
    logic [AXES-1:0] r_move_positive, r_enable, n_enable, en_base;
    logic            move_end;

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        t_lane_ctrl              ctrl;
        t_lane_stat              stat;
        logic [IN_STEP_BITS-1:0] ax_steps;
        logic [PERIOD_BITS-1:0]  ax_period;

        // axes beyond the item's four load as empty
        if (g < IN_AXES) begin : g_fed
            assign ax_steps  = in_steps[g];
            assign ax_period = in_period[g];
            assign load_pos[g] = r_in.positive_mask[g];
            assign dis_ax[g]   = r_cfg_disable[g];
        end else begin : g_unfed
            assign ax_steps  = '0;
            assign ax_period = '0;
            assign load_pos[g] = 1'b0;
            assign dis_ax[g]   = 1'b0;
        end

        // min endstop: wired, moving negative, pin differs from idle level
        if (g < ENDSTOP_AXES) begin : g_endstop
            assign hit[g] = fire && r_cfg_present[g] && !mp_next[g]
                          && (r_in.endstop_pins[g] != r_cfg_level) && live_pre[g];
        end else begin : g_no_endstop
            assign hit[g] = 1'b0;
        end

        assign ctrl.load = is_load;
        assign ctrl.tick = is_tick;
        assign ctrl.kill = hit[g];

        mspt_axis #(
            .STEP_COUNT_BITS (STEP_COUNT_BITS)
        ) u_axis (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_steps  (ax_steps),
            .i_period (ax_period),
            .o_stat   (stat)
        );

        assign was_live[g] = stat.was_live;
        assign live_pre[g] = stat.live_pre;
        assign pulse[g]    = stat.pulse;
    end

    assign mp_next    = is_load ? load_pos : r_move_positive;
    assign live_after = live_pre & ~hit;

    // drivers: a load only adds enables; the disable mask applies where the
    // last steps vanish, or on a load that leaves nothing to do
    always_comb begin
        en_base  = is_load ? (r_enable | live_pre) : r_enable;
        move_end = is_load ? (live_after == '0)
                           : (is_tick && (was_live != '0) && (live_after == '0));
        n_enable = move_end ? (en_base & ~dis_ax) : en_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_positive <= '0;
            r_enable        <= '0;
        end else begin
            r_move_positive <= mp_next;
            r_enable        <= n_enable;
        end
    end

    // ---- result assembly ----
    for (genvar b = 0; b < IN_AXES; b++) begin : g_out_bit
        if (b < AXES) begin : g_real
            assign res.step_pulses[b] = pulse[b];
            assign res.dir_pins[b]    = mp_next[b] ^ r_cfg_dir_inv[b];
            assign res.enable_pins[b] = n_enable[b];
            assign res.active_axes[b] = live_after[b];
        end else begin : g_absent
            assign res.step_pulses[b] = 1'b0;
            assign res.dir_pins[b]    = r_cfg_dir_inv[b];
            assign res.enable_pins[b] = 1'b0;
            assign res.active_axes[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < ENDSTOP_AXES; b++) begin : g_hit_bit
        if (b < AXES) begin : g_real
            assign res.endstop_hits[b] = hit[b];
        end else begin : g_absent
            assign res.endstop_hits[b] = 1'b0;
        end
    end

    assign res.busy_res = (live_after != '0);

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- assertions ----
    // an axis with steps left always has its driver enabled
    a_live_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (was_live & ~r_enable) == '0)
        else $error("axis with steps left has its driver disabled");

    // a step pulse only comes from an axis that had steps before the tick
    a_pulse_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> ((pulse & ~was_live) == '0))
        else $error("step pulse from an idle axis");

    // every consumed transaction shows up in the result register next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("result lost after compute");

    // a held transaction that is not consumed stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in)))
        else $error("input register changed while stalled");

endmodule
